// ===== rtl/gmf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared types and constants of the grid local maximum finder.
// ----------------------------------------------------------------------------
package gmf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PEAK_W      = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_row;
        logic [PEAK_W-1:0] peak_col;
    } t_peak;

endpackage

// ===== rtl/gmf_stream_if.sv =====
// ----------------------------------------------------------------------------
// gmf_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface gmf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gmf_line_store.sv =====
// ----------------------------------------------------------------------------
// gmf_line_store
// Simple dual-port line memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gmf_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gmf_peak_fifo.sv =====
// ----------------------------------------------------------------------------
// gmf_peak_fifo
// Small result queue that decouples the detector from a stalling receiver.
// ----------------------------------------------------------------------------
module gmf_peak_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  gmf_pkg::t_peak             i_push_data,
    output logic [gmf_pkg::FIFO_CNT_W-1:0] o_count,
    gmf_stream_if.source               o_out
);
    import gmf_pkg::*;

    t_peak                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign pop         = o_out.valid && o_out.ready;
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rd_ptr];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/grid_local_maximum_finder.sv =====
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// 4-neighbour local maximum detector over a raster-scanned signed grid.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one request per grid sample in raster order (command 0), then one
//            flush request per column (command 1) for the zero row below.
//   o_out  : row/column of each sample >= its up, down, left and right
//            neighbours (outside counts as zero), in raster order.
//   i_cfg_*: write grid_rows (index 0) and grid_cols (index 1) while idle;
//            a write to either of them restarts the frame.
// Throughput: one request per cycle while i_in.ready is high. Each request
//   does one read and one write of a single line memory holding {row two
//   above, row above} per column.
// Order: the decision on (r-1, c) needs the row-above sample of column
//   c+1, so it is taken when request (r, c+1) reaches the memory output;
//   the result is then written into the result queue and shows from there.
//   The last column's decision is taken alone in the pending decision stage.
// Reset: counters clear, grid is 1 x 1; the line memory is not cleared.
// Stall: a 4-deep result queue absorbs the pipe; i_in.ready drops when
//   queued plus in-flight requests would overfill it.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gmf_stream_if.sink                    i_in,
    gmf_stream_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [gmf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gmf_pkg::CFG_W-1:0]     i_cfg_data
);
    import gmf_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);   // row counter, holds flush row
    localparam int COL_W  = $clog2(MAX_COLS);       // column index
    localparam int NCOL_W = $clog2(MAX_COLS + 1);   // column count
    localparam int ROWX_W = (ROW_W > PEAK_W) ? ROW_W : PEAK_W;
    localparam int COLX_W = (COL_W > PEAK_W) ? COL_W : PEAK_W;

    typedef logic signed [SAMPLE_W-1:0] t_smp;

    // zero counts as one, above the maximum saturates
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
        int x;
        x = int'(v);
        if (x == 0) begin
            return 1;
        end
        if (x > maxv) begin
            return maxv;
        end
        return x;
    endfunction

    // configuration and position
    logic [ROW_W-1:0]  r_rows;
    logic [NCOL_W-1:0] r_cols;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;

    // memory output stage
    logic                   r_s1_valid;
    logic [ROW_W-1:0]       r_s1_row;
    logic [COL_W-1:0]       r_s1_col;
    t_smp                   r_s1_val;
    logic                   r_s1_fwd;
    logic [2*SAMPLE_W-1:0]  r_s1_fwd_data;

    // pending decision, waits for its right neighbour
    logic              r_p_valid;
    logic              r_p_last;
    logic              r_p_live;     // row above exists
    logic [PEAK_W-1:0] r_p_prow;
    logic [PEAK_W-1:0] r_p_pcol;
    t_smp              r_p_center;
    t_smp              r_p_up;
    t_smp              r_p_down;
    t_smp              r_p_left;

    logic                  accept;
    logic                  col_last;
    t_smp                  in_val;
    logic [2*SAMPLE_W-1:0] rdata;
    logic [2*SAMPLE_W-1:0] s1_entry;
    t_smp                  s1_center;
    t_smp                  s1_up;
    logic [2*SAMPLE_W-1:0] wdata;
    logic                  p_resolve;
    t_smp                  p_right;
    logic                  peak_push;
    t_peak                 peak_data;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [ROWX_W-1:0]     row_m1;
    logic [COLX_W-1:0]     col_x;

    // credit: every request in flight can still produce one result
    assign i_in.ready = (FIFO_CNT_W'(fifo_count) + FIFO_CNT_W'(r_s1_valid)
                         + FIFO_CNT_W'(r_p_valid)) < FIFO_CNT_W'(FIFO_DEPTH);
    assign accept     = i_in.valid && i_in.ready;

    assign col_last = (NCOL_W'(r_col) + NCOL_W'(1)) >= r_cols;
    assign in_val   = (i_in.data.command == CMD_FLUSH || r_row >= r_rows)
                      ? '0 : i_in.data.sample;

    gmf_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (2 * SAMPLE_W)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rdata),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (wdata)
    );

    // entry = {row two above, row above}; forward a write to the same column
    assign s1_entry  = r_s1_fwd ? r_s1_fwd_data : rdata;
    assign s1_center = s1_entry[SAMPLE_W-1:0];
    assign s1_up     = (r_s1_row > ROW_W'(1)) ? t_smp'(s1_entry[2*SAMPLE_W-1:SAMPLE_W]) : '0;
    assign wdata     = {s1_center, r_s1_val};

    // pending column resolves on the next column's center, or alone at row end
    assign p_resolve = r_p_valid && (r_p_last || r_s1_valid);
    assign p_right   = r_p_last ? '0 : s1_center;
    assign peak_push = p_resolve && r_p_live
                       && (r_p_center >= r_p_up)   && (r_p_center >= r_p_down)
                       && (r_p_center >= r_p_left) && (r_p_center >= p_right);
    assign peak_data.peak_row = r_p_prow;
    assign peak_data.peak_col = r_p_pcol;

    assign row_m1 = ROWX_W'(r_s1_row) - ROWX_W'(1);
    assign col_x  = COLX_W'(r_s1_col);

    gmf_peak_fifo u_peak_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (peak_push),
        .i_push_data (peak_data),
        .o_count     (fifo_count),
        .o_out       (o_out)
    );

    // position counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROW_W'(1);
            r_cols <= NCOL_W'(1);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we && (i_cfg_idx == REG_GRID_ROWS || i_cfg_idx == REG_GRID_COLS)) begin
            if (i_cfg_idx == REG_GRID_ROWS) begin
                r_rows <= ROW_W'(clamp_dim(i_cfg_data, MAX_ROWS));
            end else begin
                r_cols <= NCOL_W'(clamp_dim(i_cfg_data, MAX_COLS));
            end
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= (r_row >= r_rows) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // memory output stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_val      <= in_val;
            r_s1_fwd      <= r_s1_valid && (r_s1_col == r_col);
            r_s1_fwd_data <= wdata;
        end
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    // pending decision stage; left neighbour is the previous column's center
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_p_last   <= (NCOL_W'(r_s1_col) + NCOL_W'(1)) >= r_cols;
            r_p_live   <= (r_s1_row != '0);
            r_p_prow   <= row_m1[PEAK_W-1:0];
            r_p_pcol   <= col_x[PEAK_W-1:0];
            r_p_center <= s1_center;
            r_p_up     <= s1_up;
            r_p_down   <= r_s1_val;
            r_p_left   <= (r_s1_col == '0) ? '0 : r_p_center;
        end
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (r_s1_valid) begin
            r_p_valid <= 1'b1;
        end else if (p_resolve) begin
            r_p_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/gmf_checker.sv =====
// ----------------------------------------------------------------------------
// gmf_checker
// Port-level checks of the local maximum finder, bound to the top level.
// ----------------------------------------------------------------------------
module gmf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input gmf_pkg::t_peak i_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its position
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // reset leaves the block ready for a new request
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready right after reset");

    // once no request and no result has been offered long enough for the pipe to drain, input is never refused
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_valid && !i_out_valid ##1 !i_in_valid && !i_out_valid
        ##1 !i_in_valid && !i_out_valid |-> i_in_ready)
        else $error("ready low with nothing in flight");

endmodule

bind grid_local_maximum_finder gmf_checker u_gmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
